@@ rtl/button_gesture_detector_macros.svh @@
// assertion helpers shared by the gesture detector modules
`ifndef BUTTON_GESTURE_DETECTOR_MACROS_SVH
`define BUTTON_GESTURE_DETECTOR_MACROS_SVH

// checked on every clock edge outside reset
`define BGD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define BGD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/bgd_pkg.sv @@
`default_nettype none

package bgd_pkg;

  localparam int unsigned TickW  = 16;
  localparam int unsigned DebW   = 3;
  localparam int unsigned ShakeW = 8;
  localparam int unsigned RepW   = 4;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [TickW-1:0] TickMax = '1;
  localparam logic [DebW-1:0]  DebMax  = '1;
  localparam logic [RepW-1:0]  RepMax  = '1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_ACTIVE_LEVEL = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SHAKE_OFF    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SHORT        = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LONG         = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_CLAMP        = 3'd5;

  // configuration reset values
  localparam logic              RstActiveLevel = 1'b0;
  localparam logic [DebW-1:0]   RstDebounce    = 3'd3;
  localparam logic [ShakeW-1:0] RstShakeOff    = 8'd2;
  localparam logic [TickW-1:0]  RstShort       = 16'd60;
  localparam logic [TickW-1:0]  RstLong        = 16'd200;
  localparam logic [TickW-1:0]  RstClamp       = 16'd0;

  typedef enum logic [3:0] {
    EV_NONE       = 4'd0,
    EV_DOWN       = 4'd1,
    EV_UP         = 4'd2,
    EV_SINGLE     = 4'd4,
    EV_DOUBLE     = 4'd5,
    EV_LONG_START = 4'd6,
    EV_LONG_HOLD  = 4'd7,
    EV_CLAMP      = 4'd8
  } event_t;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_PRESSED  = 3'd1,
    ST_RELEASED = 3'd2,
    ST_REPEAT   = 3'd3,
    ST_LONG     = 3'd5,
    ST_HELD     = 3'd6
  } state_t;

  typedef struct packed {
    logic              press_level;
    logic [DebW-1:0]   settle_ticks;
    logic [ShakeW-1:0] shake_off_ticks;
    logic [TickW-1:0]  gap_ticks;
    logic [TickW-1:0]  long_ticks;
    logic [TickW-1:0]  clamp_err_ticks;
  } cfg_t;

  typedef struct packed {
    event_t          fired_event;
    logic            repeat_fired;
    event_t          latched_event;
    logic [RepW-1:0] repeat_count;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/bgd_core.sv @@
`default_nettype none

`include "button_gesture_detector_macros.svh"

module bgd_core
  import bgd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic step,
  input  wire logic pin_sample,
  input  wire cfg_t cfg,
  output res_t      res
);

  state_t          state, state_next;
  logic [TickW-1:0] tick_count, tick_count_next;
  logic [DebW-1:0]  debounce_count, debounce_count_next;
  logic             stable_level, stable_level_next;
  logic [RepW-1:0]  press_repeats, press_repeats_next;
  event_t           last_event, last_event_next;

  logic [TickW-1:0] tick_inc;
  logic [DebW-1:0]  deb_inc;
  logic             pressed;
  logic             long_on;
  logic [TickW-1:0] shake_ext;
  event_t           fired;
  logic             rep;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      tick_count     <= '0;
      debounce_count <= '0;
      stable_level   <= 1'b0;
      press_repeats  <= '0;
      last_event     <= EV_NONE;
    end else if (step) begin
      state          <= state_next;
      tick_count     <= tick_count_next;
      debounce_count <= debounce_count_next;
      stable_level   <= stable_level_next;
      press_repeats  <= press_repeats_next;
      last_event     <= last_event_next;
    end
  end

  always_comb begin
    tick_inc  = (tick_count != TickMax) ? tick_count + 1'b1 : tick_count;
    deb_inc   = (debounce_count != DebMax) ? debounce_count + 1'b1 : debounce_count;
    shake_ext = {{(TickW-ShakeW){1'b0}}, cfg.shake_off_ticks};
    long_on   = (cfg.long_ticks != '0);

    // debounce: the stable level moves after a run of differing samples
    stable_level_next   = stable_level;
    debounce_count_next = '0;
    if (pin_sample != stable_level) begin
      if (deb_inc >= cfg.settle_ticks) begin
        stable_level_next = pin_sample;
      end else begin
        debounce_count_next = deb_inc;
      end
    end
    pressed = (stable_level_next == cfg.press_level);

    state_next         = state;
    tick_count_next    = tick_inc;
    press_repeats_next = press_repeats;
    last_event_next    = last_event;
    fired              = EV_NONE;
    rep                = 1'b0;

    case (state)
      ST_IDLE: begin
        if (pressed) begin
          if (tick_inc >= shake_ext) begin
            fired              = EV_DOWN;
            tick_count_next    = '0;
            press_repeats_next = {{(RepW-1){1'b0}}, 1'b1};
            state_next         = ST_PRESSED;
          end
        end else begin
          last_event_next = EV_NONE;
          tick_count_next = '0;
        end
      end
      ST_PRESSED: begin
        if (!pressed) begin
          if (tick_inc >= shake_ext) begin
            fired           = EV_UP;
            tick_count_next = '0;
            state_next      = ST_RELEASED;
          end
        end else if (tick_inc > cfg.long_ticks) begin
          if (long_on) fired = EV_LONG_START;
          state_next = ST_LONG;
        end
      end
      ST_RELEASED: begin
        if (pressed) begin
          fired = EV_DOWN;
          rep   = 1'b1;
          if (press_repeats != RepMax) press_repeats_next = press_repeats + 1'b1;
          tick_count_next = '0;
          state_next      = ST_REPEAT;
        end else if (tick_inc > cfg.gap_ticks) begin
          if (press_repeats == RepW'(1)) begin
            fired = EV_SINGLE;
          end else if (press_repeats == RepW'(2)) begin
            fired = EV_DOUBLE;
          end
          state_next = ST_IDLE;
        end
      end
      ST_REPEAT: begin
        if (!pressed) begin
          fired = EV_UP;
          if (tick_inc < cfg.gap_ticks) begin
            tick_count_next = '0;
            state_next      = ST_RELEASED;
          end else begin
            state_next = ST_IDLE;
          end
        end else if (tick_inc > cfg.gap_ticks) begin
          state_next = ST_IDLE;
        end
      end
      ST_LONG: begin
        if (pressed) begin
          if (long_on) fired = EV_LONG_HOLD;
          state_next = ST_HELD;
        end else begin
          fired      = EV_UP;
          state_next = ST_IDLE;
        end
      end
      ST_HELD: begin
        if (pressed) begin
          // stuck button: clamp the counter so the error fires every tick
          if (cfg.clamp_err_ticks != '0 && tick_inc > cfg.clamp_err_ticks) begin
            tick_count_next = cfg.clamp_err_ticks;
            fired           = EV_CLAMP;
          end
        end else begin
          fired      = EV_UP;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (fired != EV_NONE) last_event_next = fired;

    res.fired_event   = fired;
    res.repeat_fired  = rep;
    res.latched_event = last_event_next;
    res.repeat_count  = press_repeats_next;
  end

  `BGD_ASSERT(a_repeats_live, (state != ST_IDLE) |-> (press_repeats != '0), "no press counted in an active gesture")
  `BGD_ASSERT(a_repeat_is_down, res.repeat_fired |-> (res.fired_event == EV_DOWN), "repeat without a press down")
  `BGD_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == ST_IDLE && tick_count == '0), "reset left the machine active")

endmodule

`default_nettype wire

@@ rtl/button_gesture_detector.sv @@
`default_nettype none

`include "button_gesture_detector_macros.svh"

// Debounces a sampled button pin and classifies gestures (press down and up,
// repeat press, single and double click, long press start and hold, stuck
// button clamp). Every sample transfer gives exactly one result transfer. A
// sample is taken in every cycle while the result register is free or being
// emptied, and its result appears in the next cycle; the combinational gesture
// step between the state registers and the result register sets that rate.
// Configuration writes go to the register named by cfg_index and should be
// made while no result is pending.

module button_gesture_detector
  import bgd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  input  wire logic                sample_valid,
  output logic                     sample_stall,
  input  wire logic                pin_sample,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output logic [3:0]               fired_event,
  output logic                     repeat_fired,
  output logic [3:0]               latched_event,
  output logic [RepW-1:0]          repeat_count
);

  cfg_t cfg;
  res_t step_res;
  res_t result;
  logic sample_take;

  assign sample_stall = result_valid & result_stall;
  assign sample_take  = sample_valid & ~sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_level     <= RstActiveLevel;
      cfg.settle_ticks    <= RstDebounce;
      cfg.shake_off_ticks <= RstShakeOff;
      cfg.gap_ticks       <= RstShort;
      cfg.long_ticks      <= RstLong;
      cfg.clamp_err_ticks <= RstClamp;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ACTIVE_LEVEL: cfg.press_level     <= cfg_data[0];
        REG_DEBOUNCE:     cfg.settle_ticks    <= cfg_data[DebW-1:0];
        REG_SHAKE_OFF:    cfg.shake_off_ticks <= cfg_data[ShakeW-1:0];
        REG_SHORT:        cfg.gap_ticks       <= cfg_data[TickW-1:0];
        REG_LONG:         cfg.long_ticks      <= cfg_data[TickW-1:0];
        REG_CLAMP:        cfg.clamp_err_ticks <= cfg_data[TickW-1:0];
        default: ;
      endcase
    end
  end

  bgd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (sample_take),
    .pin_sample (pin_sample),
    .cfg        (cfg),
    .res        (step_res)
  );

  // result register, refilled on the same edge it is emptied
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (sample_take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_take) result <= step_res;
  end

  assign fired_event   = result.fired_event;
  assign repeat_fired  = result.repeat_fired;
  assign latched_event = result.latched_event;
  assign repeat_count  = result.repeat_count;

  `BGD_ASSERT(a_take_gives_result, sample_take |=> result_valid, "sample transfer gave no result")
  `BGD_ASSERT(a_latch_follows_fire, (result_valid && fired_event != EV_NONE) |-> (latched_event == fired_event), "fired event not latched")

endmodule

`default_nettype wire
